### hw/rtl/sparse_neuron_tanh_macros.svh
// ----------------------------------------------------------------------------
// Sparse neuron assertion macros
// Shared concurrent assertion forms used by the sparse neuron RTL.
// ----------------------------------------------------------------------------
`ifndef SPARSE_NEURON_TANH_MACROS_SVH
`define SPARSE_NEURON_TANH_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SNT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sparse_neuron_tanh: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SNT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sparse_neuron_tanh: assertion failed");

`endif

### hw/rtl/snt_pkg.sv
// ----------------------------------------------------------------------------
// Sparse neuron package
// Item codes, queue entry type, sizes and the tanh breakpoint table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package snt_pkg;

   localparam int NUM_SOURCES_DEFAULT = 64;
   localparam int QUEUE_DEPTH         = 4;
   localparam int RAM_WIDTH           = 17;

   localparam logic [2:0] MODE_WRITE  = 3'd0;
   localparam logic [2:0] MODE_REMOVE = 3'd1;
   localparam logic [2:0] MODE_QUERY  = 3'd2;
   localparam logic [2:0] MODE_SET    = 3'd3;
   localparam logic [2:0] MODE_FEED   = 3'd4;

   typedef struct packed {
      logic [2:0]         mode;
      logic               in_range;
      logic [5:0]         neuron_index;
      logic signed [15:0] data;
      logic               last;
   } op_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_ctrl_type;

   function automatic logic [12:0] tanh_point(input logic [4:0] k);
      logic [12:0] y;
      case (k)
         5'd0:    y = 13'd0;
         5'd1:    y = 13'd1003;
         5'd2:    y = 13'd1893;
         5'd3:    y = 13'd2602;
         5'd4:    y = 13'd3119;
         5'd5:    y = 13'd3475;
         5'd6:    y = 13'd3707;
         5'd7:    y = 13'd3856;
         5'd8:    y = 13'd3949;
         5'd9:    y = 13'd4006;
         5'd10:   y = 13'd4041;
         5'd11:   y = 13'd4062;
         5'd12:   y = 13'd4076;
         5'd13:   y = 13'd4084;
         5'd14:   y = 13'd4089;
         5'd15:   y = 13'd4091;
         5'd16:   y = 13'd4093;
         default: y = 13'd0;
      endcase
      return y;
   endfunction

endpackage

### hw/rtl/snt_ram.sv
// ----------------------------------------------------------------------------
// Sparse neuron generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module snt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/snt_front.sv
// ----------------------------------------------------------------------------
// Sparse neuron front end
// Accepts request transactions, drops those with no effect and queues the rest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module snt_front #(
   parameter int NUM_SOURCES = snt_pkg::NUM_SOURCES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [2:0]            req_mode,
   input  logic [5:0]            req_neuron_index,
   input  logic signed [15:0]    req_data_in,
   input  logic                  req_last,
   input  snt_pkg::back_ctrl_type back_ctrl,
   output logic                  op_valid,
   output snt_pkg::op_type       op
);

   localparam int PW = $clog2(snt_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(snt_pkg::QUEUE_DEPTH + 1);

   snt_pkg::op_type q_ff [snt_pkg::QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            full;
   logic            in_range;
   logic            keep;
   logic            push;
   logic            pop;
   snt_pkg::op_type entry;

   assign full      = (count_ff == CW'(snt_pkg::QUEUE_DEPTH));
   assign req_stall = full | back_ctrl.clearing;
   assign in_range  = (32'(req_neuron_index) < NUM_SOURCES);

   always_comb begin
      case (req_mode)
         snt_pkg::MODE_WRITE, snt_pkg::MODE_REMOVE: keep = in_range;
         snt_pkg::MODE_QUERY, snt_pkg::MODE_SET, snt_pkg::MODE_FEED: keep = 1'b1;
         default: keep = 1'b0;
      endcase
   end

   always_comb begin
      entry.mode         = req_mode;
      entry.in_range     = in_range;
      entry.neuron_index = req_neuron_index;
      entry.data         = req_data_in;
      entry.last         = req_last;
   end

   assign push      = req_valid & ~req_stall & keep;
   assign pop       = back_ctrl.pop;
   assign wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

   assign op_valid = (count_ff != '0);
   assign op       = q_ff[rd_ptr_ff];

endmodule

### hw/rtl/snt_back.sv
// ----------------------------------------------------------------------------
// Sparse neuron back end
// Executes queued transactions against the connection table and the neuron.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module snt_back #(
   parameter int NUM_SOURCES = snt_pkg::NUM_SOURCES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   op_valid,
   input  snt_pkg::op_type        op,
   output snt_pkg::back_ctrl_type back_ctrl,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [13:0]     rsp_activation,
   output logic signed [15:0]     rsp_weight_out,
   output logic                   rsp_exists,
   output logic                   rsp_update_done
);

   localparam int AW = $clog2(NUM_SOURCES);
   localparam int XW = (AW > 6) ? AW : 6;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_ACC   = 3'd3;
   localparam logic [2:0] ST_MAG   = 3'd4;
   localparam logic [2:0] ST_TANH  = 3'd5;
   localparam logic [2:0] ST_EMIT  = 3'd6;

   logic [2:0]                  state_ff, state_in;
   logic [AW-1:0]               clr_cnt_ff, clr_cnt_in;
   snt_pkg::op_type             cur_ff, cur_in;
   logic signed [31:0]          product_ff, product_in;
   logic [47:0]                 acc_ff, acc_in;
   logic signed [13:0]          neuron_ff, neuron_in;
   logic                        neg_ff, neg_in;
   logic                        sat_ff, sat_in;
   logic [3:0]                  seg_ff, seg_in;
   logic [11:0]                 frac_ff, frac_in;
   logic signed [15:0]          pend_weight_ff, pend_weight_in;
   logic                        pend_exists_ff, pend_exists_in;
   logic                        pend_done_ff, pend_done_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [13:0]          rsp_act_ff;
   logic signed [15:0]          rsp_weight_ff;
   logic                        rsp_exists_ff;
   logic                        rsp_done_ff;
   logic                        rsp_load;

   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic [snt_pkg::RAM_WIDTH-1:0] wr_data;
   logic                        rd_en;
   logic [snt_pkg::RAM_WIDTH-1:0] rd_data;
   logic [XW-1:0]               idx_x;
   logic [AW-1:0]               op_addr;
   logic                        ex;
   logic signed [15:0]          w_s;
   logic [47:0]                 mag;
   logic [12:0]                 t_lo, t_hi, t_d;
   logic [24:0]                 t_prod;
   logic [25:0]                 t_sum;
   logic [12:0]                 y;
   logic                        rsp_free;

   assign idx_x   = XW'(op.neuron_index);
   assign op_addr = idx_x[AW-1:0];
   assign ex      = cur_ff.in_range & rd_data[16];
   assign w_s     = rd_data[15:0];
   assign mag     = acc_ff[47] ? (~acc_ff + 48'd1) : acc_ff;
   assign t_lo    = snt_pkg::tanh_point({1'b0, seg_ff});
   assign t_hi    = snt_pkg::tanh_point({1'b0, seg_ff} + 5'd1);
   assign t_d     = t_hi - t_lo;
   assign t_prod  = 25'(t_d) * 25'(frac_ff);
   assign t_sum   = 26'(t_prod) + 26'd2048;
   assign y       = sat_ff ? 13'd4096 : t_lo + t_sum[24:12];
   assign rsp_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in       = state_ff;
      clr_cnt_in     = clr_cnt_ff;
      cur_in         = cur_ff;
      product_in     = product_ff;
      acc_in         = acc_ff;
      neuron_in      = neuron_ff;
      neg_in         = neg_ff;
      sat_in         = sat_ff;
      seg_in         = seg_ff;
      frac_in        = frac_ff;
      pend_weight_in = pend_weight_ff;
      pend_exists_in = pend_exists_ff;
      pend_done_in   = pend_done_ff;
      back_ctrl      = '0;
      wr_en          = 1'b0;
      wr_addr        = op_addr;
      wr_data        = '0;
      rd_en          = 1'b0;
      rsp_load       = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            back_ctrl.clearing = 1'b1;
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(NUM_SOURCES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (op_valid) begin
               back_ctrl.pop = 1'b1;
               cur_in        = op;
               case (op.mode)
                  snt_pkg::MODE_WRITE: begin
                     wr_en   = 1'b1;
                     wr_data = {1'b1, op.data};
                  end
                  snt_pkg::MODE_REMOVE: begin
                     wr_en = 1'b1;
                  end
                  snt_pkg::MODE_SET: begin
                     if (op.data > 16'sd4096) begin
                        neuron_in = 14'sd4096;
                     end else if (op.data < -16'sd4096) begin
                        neuron_in = -14'sd4096;
                     end else begin
                        neuron_in = 14'(op.data);
                     end
                  end
                  snt_pkg::MODE_QUERY, snt_pkg::MODE_FEED: begin
                     rd_en    = 1'b1;
                     state_in = ST_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            if (cur_ff.mode == snt_pkg::MODE_QUERY) begin
               pend_weight_in = ex ? w_s : 16'sd0;
               pend_exists_in = ex;
               pend_done_in   = 1'b0;
               state_in       = ST_EMIT;
            end else begin
               product_in = ex ? 32'(w_s) * 32'(cur_ff.data) : 32'sd0;
               state_in   = ST_ACC;
            end
         end
         ST_ACC: begin
            acc_in   = acc_ff + {{16{product_ff[31]}}, product_ff};
            state_in = cur_ff.last ? ST_MAG : ST_IDLE;
         end
         ST_MAG: begin
            neg_in   = acc_ff[47];
            sat_in   = |mag[47:26];
            seg_in   = mag[25:22];
            frac_in  = mag[21:10];
            acc_in   = '0;
            state_in = ST_TANH;
         end
         ST_TANH: begin
            neuron_in      = neg_ff ? -14'(y) : 14'(y);
            pend_weight_in = 16'sd0;
            pend_exists_in = 1'b0;
            pend_done_in   = 1'b1;
            state_in       = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         acc_ff       <= '0;
         neuron_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         acc_ff       <= acc_in;
         neuron_ff    <= neuron_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      product_ff     <= product_in;
      neg_ff         <= neg_in;
      sat_ff         <= sat_in;
      seg_ff         <= seg_in;
      frac_ff        <= frac_in;
      pend_weight_ff <= pend_weight_in;
      pend_exists_ff <= pend_exists_in;
      pend_done_ff   <= pend_done_in;
      if (rsp_load) begin
         rsp_act_ff    <= neuron_ff;
         rsp_weight_ff <= pend_weight_ff;
         rsp_exists_ff <= pend_exists_ff;
         rsp_done_ff   <= pend_done_ff;
      end
   end

   snt_ram #(
      .WIDTH(snt_pkg::RAM_WIDTH),
      .DEPTH(NUM_SOURCES)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(op_addr),
      .rd_data(rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_activation  = rsp_act_ff;
   assign rsp_weight_out  = rsp_weight_ff;
   assign rsp_exists      = rsp_exists_ff;
   assign rsp_update_done = rsp_done_ff;

endmodule

### hw/rtl/sparse_neuron_tanh.sv
// ----------------------------------------------------------------------------
// Sparse neuron with tanh activation
// One neuron with a sparse table of weighted incoming connections.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  req_*    in         mode, neuron index, Q4.12 data and last mark
//  rsp_*    out        activation, queried weight, exists flag, pass done
//
// A queued write, remove or set is done by the back end in its idle state. A
// query reads the table, then emits; a feed reads the table and accumulates,
// and on the last value of a pass also takes the magnitude, looks up tanh and
// emits. After reset a clearing pass empties the table; req_stall is high
// during it. A four-entry queue keeps taking transactions, until it is full,
// while the back end works or rsp_stall holds a result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sparse_neuron_tanh_macros.svh"

module sparse_neuron_tanh #(
   parameter int NUM_SOURCES = snt_pkg::NUM_SOURCES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_mode,
   input  logic [5:0]         req_neuron_index,
   input  logic signed [15:0] req_data_in,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [13:0] rsp_activation,
   output logic signed [15:0] rsp_weight_out,
   output logic               rsp_exists,
   output logic               rsp_update_done
);

   snt_pkg::back_ctrl_type back_ctrl;
   snt_pkg::op_type        op;
   logic                   op_valid;

   snt_front #(
      .NUM_SOURCES(NUM_SOURCES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_neuron_index(req_neuron_index),
      .req_data_in     (req_data_in),
      .req_last        (req_last),
      .back_ctrl       (back_ctrl),
      .op_valid        (op_valid),
      .op              (op)
   );

   snt_back #(
      .NUM_SOURCES(NUM_SOURCES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .op_valid       (op_valid),
      .op             (op),
      .back_ctrl      (back_ctrl),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_activation (rsp_activation),
      .rsp_weight_out (rsp_weight_out),
      .rsp_exists     (rsp_exists),
      .rsp_update_done(rsp_update_done)
   );

   `SNT_ASSERT_SAME(a_clear_stalls, clock, reset, back_ctrl.clearing, req_stall && !back_ctrl.pop)
   `SNT_ASSERT_SAME(a_act_range, clock, reset, rsp_valid, rsp_activation <= 14'sd4096 && rsp_activation >= -14'sd4096)
   `SNT_ASSERT_SAME(a_done_no_entry, clock, reset, rsp_valid && rsp_update_done, !rsp_exists && rsp_weight_out == 16'sd0)
   `SNT_ASSERT_NEXT(a_pop_after_clear, clock, reset, back_ctrl.pop, !back_ctrl.clearing)

endmodule

### verif/tb_sparse_neuron_tanh.sv
// ----------------------------------------------------------------------------
// Sparse neuron testbench
// Drives connection writes, removes, queries, value sets and feed passes into
// the neuron, predicts every result with its own table, accumulator and tanh
// curve, and compares each result field by field. A short table of directed
// transactions comes first, then random sequences with random idle and stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sparse_neuron_tanh;

   localparam int NUM_SRC      = snt_pkg::NUM_SOURCES_DEFAULT;
   localparam int MAX_IDLE     = 16;
   localparam int LONG_HOLD    = 300;
   localparam int QUIET_LIMIT  = 3000;
   localparam int RANDOM_ITEMS = 1100;
   localparam int DRAIN_CYCLES = 40;
   localparam int ONE_Q12      = 4096;

   localparam logic [2:0] MODE_SPARE_LO = 3'd5;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;

   localparam int TANH_PTS [17] = '{
      0, 1003, 1893, 2602, 3119, 3475, 3707, 3856, 3949,
      4006, 4041, 4062, 4076, 4084, 4089, 4091, 4093
   };

   typedef struct packed {
      logic signed [13:0] act;
      logic signed [15:0] weight;
      logic               exists;
      logic               done;
   } rsp_type;

   typedef struct packed {
      logic [2:0]         mode;
      logic [5:0]         idx;
      logic signed [15:0] data;
      logic               last;
      logic               fixed;
      rsp_type            want;
   } stim_row_type;

   localparam rsp_type NO_RSP = '{0, 0, 0, 0};

   logic               clock;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic               req_stall;
   logic [2:0]         req_mode         = '0;
   logic [5:0]         req_neuron_index = '0;
   logic signed [15:0] req_data_in      = '0;
   logic               req_last         = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall        = 1'b0;
   logic signed [13:0] rsp_activation;
   logic signed [15:0] rsp_weight_out;
   logic               rsp_exists;
   logic               rsp_update_done;

   logic signed [15:0] wt_mem [NUM_SRC];
   logic               wt_valid [NUM_SRC];
   logic signed [47:0] dot_sum;
   logic signed [15:0] cur_value;

   rsp_type pending_rsp [$];
   int   mismatches  = 0;
   int   quiet_cycles = 0;
   bit   idle_on     = 1'b1;
   bit   hold_rsp    = 1'b0;

   stim_row_type dir_rows [25] = '{
      '{snt_pkg::MODE_QUERY,  6'd0,  16'sd0,  1'b0, 1'b1, '{14'sd0, 16'sd0, 1'b0, 1'b0}},
      '{snt_pkg::MODE_QUERY,  6'd63, 16'sd0,  1'b0, 1'b1, '{14'sd0, 16'sd0, 1'b0, 1'b0}},
      '{snt_pkg::MODE_FEED,   6'd5,  16'sd32767, 1'b1, 1'b1, '{14'sd0, 16'sd0, 1'b0, 1'b1}},
      '{snt_pkg::MODE_WRITE,  6'd0,  16'sd32767, 1'b0, 1'b0, NO_RSP},
      '{snt_pkg::MODE_WRITE,  6'd63, -16'sd32768, 1'b0, 1'b0, NO_RSP},
      '{snt_pkg::MODE_QUERY,  6'd0,  16'sd0,  1'b0, 1'b1, '{14'sd0, 16'sd32767, 1'b1, 1'b0}},
      '{snt_pkg::MODE_QUERY,  6'd63, 16'sd0,  1'b0, 1'b1, '{14'sd0, -16'sd32768, 1'b1, 1'b0}},
      '{snt_pkg::MODE_FEED,   6'd0,  16'sd32767, 1'b1, 1'b1, '{14'sd4096, 16'sd0, 1'b0, 1'b1}},
      '{snt_pkg::MODE_FEED,   6'd63, 16'sd32767, 1'b1, 1'b1, '{-14'sd4096, 16'sd0, 1'b0, 1'b1}},
      '{snt_pkg::MODE_SET,    6'd0,  16'sd32767, 1'b0, 1'b0, NO_RSP},
      '{snt_pkg::MODE_QUERY,  6'd1,  16'sd0,  1'b0, 1'b1, '{14'sd4096, 16'sd0, 1'b0, 1'b0}},
      '{snt_pkg::MODE_SET,    6'd0,  -16'sd32768, 1'b0, 1'b0, NO_RSP},
      '{snt_pkg::MODE_QUERY,  6'd1,  16'sd0,  1'b0, 1'b1, '{-14'sd4096, 16'sd0, 1'b0, 1'b0}},
      '{snt_pkg::MODE_SET,    6'd0,  16'sd100, 1'b1, 1'b0, NO_RSP},
      '{snt_pkg::MODE_REMOVE, 6'd0,  16'sd0,  1'b0, 1'b0, NO_RSP},
      '{snt_pkg::MODE_REMOVE, 6'd10, 16'sd0,  1'b0, 1'b0, NO_RSP},
      '{snt_pkg::MODE_QUERY,  6'd0,  16'sd0,  1'b1, 1'b1, '{14'sd100, 16'sd0, 1'b0, 1'b0}},
      '{snt_pkg::MODE_WRITE,  6'd3,  16'sd4096, 1'b0, 1'b0, NO_RSP},
      '{snt_pkg::MODE_FEED,   6'd3,  16'sd2048, 1'b0, 1'b0, NO_RSP},
      '{snt_pkg::MODE_FEED,   6'd3,  16'sd2048, 1'b1, 1'b0, NO_RSP},
      '{MODE_SPARE_LO, 6'd3, -16'sd1, 1'b1, 1'b0, NO_RSP},
      '{MODE_SPARE_HI, 6'd63, 16'sd32767, 1'b1, 1'b0, NO_RSP},
      '{snt_pkg::MODE_QUERY,  6'd3,  16'sd0,  1'b0, 1'b0, NO_RSP},
      '{snt_pkg::MODE_FEED,   6'd3,  -16'sd1024, 1'b1, 1'b0, NO_RSP},
      '{snt_pkg::MODE_QUERY,  6'd63, 16'sd0,  1'b0, 1'b0, NO_RSP}
   };

   sparse_neuron_tanh uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_neuron_index (req_neuron_index),
      .req_data_in      (req_data_in),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_activation   (rsp_activation),
      .rsp_weight_out   (rsp_weight_out),
      .rsp_exists       (rsp_exists),
      .rsp_update_done  (rsp_update_done)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [15:0] tanh_q12(input logic signed [47:0] acc);
      logic [47:0] mag;
      int          seg;
      int          frac;
      int          y;
      mag = acc[47] ? -acc : acc;
      if (mag >= 48'h4000000) begin
         y = ONE_Q12;
      end else begin
         seg  = int'(mag[25:22]);
         frac = int'(mag[21:10]);
         y = TANH_PTS[seg] + (((TANH_PTS[seg + 1] - TANH_PTS[seg]) * frac + 2048) >>> 12);
      end
      return acc[47] ? 16'(-y) : 16'(y);
   endfunction

   task automatic neuron_predict(input logic [2:0] mode, input logic [5:0] idx,
                                 input logic signed [15:0] data, input logic last,
                                 output bit has, output rsp_type out);
      int  prod;
      bit  present;
      has = 1'b0;
      out = NO_RSP;
      present = (idx < NUM_SRC) && wt_valid[idx];
      case (mode)
         snt_pkg::MODE_WRITE: begin
            if (idx < NUM_SRC) begin
               wt_mem[idx]   = data;
               wt_valid[idx] = 1'b1;
            end
         end
         snt_pkg::MODE_REMOVE: begin
            if (idx < NUM_SRC) begin
               wt_mem[idx]   = '0;
               wt_valid[idx] = 1'b0;
            end
         end
         snt_pkg::MODE_QUERY: begin
            has        = 1'b1;
            out.act    = cur_value[13:0];
            out.weight = present ? wt_mem[idx] : '0;
            out.exists = present;
            out.done   = 1'b0;
         end
         snt_pkg::MODE_SET: begin
            if (data > ONE_Q12) cur_value = 16'(ONE_Q12);
            else if (data < -ONE_Q12) cur_value = 16'(-ONE_Q12);
            else cur_value = data;
         end
         snt_pkg::MODE_FEED: begin
            if (present) begin
               prod    = wt_mem[idx] * data;
               dot_sum = dot_sum + {{16{prod[31]}}, prod};
            end
            if (last) begin
               cur_value = tanh_q12(dot_sum);
               dot_sum   = '0;
               has       = 1'b1;
               out.act   = cur_value[13:0];
               out.done  = 1'b1;
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_txn(input logic [2:0] mode, input logic [5:0] idx,
                           input logic signed [15:0] data, input logic last,
                           input bit fixed, input rsp_type want);
      int      gap;
      bit      has;
      rsp_type got;
      gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_neuron_index <= idx;
      req_data_in      <= data;
      req_last         <= last;
      do @(posedge clock); while (req_stall);
      neuron_predict(mode, idx, data, last, has, got);
      if (has) pending_rsp.push_back(fixed ? want : got);
   endtask

   function automatic logic signed [15:0] rand_data();
      int v;
      if ($urandom_range(0, 3) == 0) return 16'($urandom);
      v = int'($urandom_range(0, 4096)) - 2048;
      return 16'(v);
   endfunction

   task automatic drain_pending();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic random_sequence(output int n);
      int choice;
      int len;
      choice = $urandom_range(0, 99);
      n = 1;
      if (choice < 15) begin
         send_txn(snt_pkg::MODE_WRITE, 6'($urandom), rand_data(), 1'($urandom), 1'b0,
                  NO_RSP);
      end else if (choice < 22) begin
         send_txn(snt_pkg::MODE_REMOVE, 6'($urandom), 16'($urandom), 1'($urandom), 1'b0,
                  NO_RSP);
      end else if (choice < 37) begin
         send_txn(snt_pkg::MODE_QUERY, 6'($urandom), 16'($urandom), 1'($urandom), 1'b0,
                  NO_RSP);
      end else if (choice < 45) begin
         send_txn(snt_pkg::MODE_SET, 6'($urandom), rand_data(), 1'($urandom), 1'b0,
                  NO_RSP);
      end else if (choice < 50) begin
         send_txn(3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)), 6'($urandom),
                  16'($urandom), 1'($urandom), 1'b0, NO_RSP);
      end else begin
         len = $urandom_range(1, 8);
         n = len;
         for (int j = 0; j < len; j++) begin
            send_txn(snt_pkg::MODE_FEED, 6'($urandom), rand_data(), j == len - 1, 1'b0,
                     NO_RSP);
         end
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected transaction activation", rsp_activation, 0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_activation !== want.act)
               report_mismatch("activation", rsp_activation, want.act);
            if (rsp_weight_out !== want.weight)
               report_mismatch("weight_out", rsp_weight_out, want.weight);
            if (rsp_exists !== want.exists)
               report_mismatch("exists", rsp_exists, want.exists);
            if (rsp_update_done !== want.done)
               report_mismatch("update_done", rsp_update_done, want.done);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_sparse_neuron_tanh: done, errors");
            $finish;
         end
      end
   end

   initial begin : rsp_side
      int hold;
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            hold = LONG_HOLD;
         end else begin
            hold = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid || reset);
      end
   end

   initial begin : req_side
      int  count;
      int  n;
      bit  pressed;
      bit  paused;
      for (int i = 0; i < NUM_SRC; i++) begin
         wt_mem[i]   = '0;
         wt_valid[i] = 1'b0;
      end
      dot_sum   = '0;
      cur_value = '0;
      count     = 0;
      pressed   = 1'b0;
      paused    = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         send_txn(dir_rows[i].mode, dir_rows[i].idx, dir_rows[i].data, dir_rows[i].last,
                  dir_rows[i].fixed, dir_rows[i].want);
      end

      while (count < RANDOM_ITEMS) begin
         if ($urandom_range(0, 59) == 0) idle_on = ~idle_on;
         if (!pressed && count >= 400) begin
            pressed = 1'b1;
            drain_pending();
            hold_rsp = 1'b1;
            idle_on  = 1'b0;
            for (int j = 0; j < 24; j++) begin
               send_txn(snt_pkg::MODE_QUERY, 6'($urandom), 16'($urandom), 1'b0, 1'b0,
                        NO_RSP);
            end
            idle_on = 1'b1;
            count += 24;
         end
         if (!paused && count >= 800) begin
            paused = 1'b1;
            drain_pending();
         end
         random_sequence(n);
         count += n;
      end

      drain_pending();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_sparse_neuron_tanh: done, clean");
      end else begin
         $display("tb_sparse_neuron_tanh: done, errors");
      end
      $finish;
   end

endmodule
